FILE: hw/rtl/tfp_pkg.sv
package tfp_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned POS_W = 3;
   localparam int unsigned SEQ_W = 6;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 32;
   localparam int unsigned RSP_USER_W = 8;

   typedef enum logic [3:0] {
      EV_IGNORED  = 4'd0,
      EV_START    = 4'd1,
      EV_LENGTH   = 4'd2,
      EV_ID       = 4'd3,
      EV_PAYLOAD  = 4'd4,
      EV_SEQ_OK   = 4'd5,
      EV_DONE     = 4'd6,
      EV_CSUM_ERR = 4'd7,
      EV_SEQ_ERR  = 4'd8,
      EV_NO_START = 4'd9
   } event_type;

   typedef struct packed {
      logic [POS_W-1:0]  packet_position;
      logic [BYTE_W-1:0] rx_byte;
   } in_beat_type;

   typedef struct packed {
      event_type         event_res;
      logic [BYTE_W-1:0] msg_id;
      logic [BYTE_W-1:0] msg_len;
      logic [BYTE_W-1:0] payload_index;
      logic [BYTE_W-1:0] payload_byte;
   } result_type;

endpackage

FILE: hw/rtl/tfp_in_reg.sv
module tfp_in_reg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tfp_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             advance,
   output logic                             beat_valid,
   output tfp_pkg::in_beat_type             beat
);

   logic                 valid_ff;
   logic                 valid_in;
   tfp_pkg::in_beat_type beat_ff;

   assign req_tready = !valid_ff || advance;
   assign valid_in = (req_tvalid && req_tready) || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         beat_ff.rx_byte <= req_tdata[tfp_pkg::BYTE_W-1:0];
         beat_ff.packet_position <=
            req_tdata[tfp_pkg::BYTE_W +: tfp_pkg::POS_W];
      end
   end

   assign beat_valid = valid_ff;
   assign beat = beat_ff;

endmodule

FILE: hw/rtl/tfp_parser.sv
module tfp_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  tfp_pkg::in_beat_type   beat,
   output tfp_pkg::result_type    result
);

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_ERROR   = 3'd1,
      PH_START   = 3'd2,
      PH_LEN     = 3'd3,
      PH_ID      = 3'd4,
      PH_SEQ     = 3'd5,
      PH_PAYLOAD = 3'd6,
      PH_DONE    = 3'd7
   } phase_type;

   phase_type                      phase_ff, phase_in;
   logic [tfp_pkg::BYTE_W-1:0]     sum_ff, sum_in;
   logic [tfp_pkg::BYTE_W-1:0]     length_ff, length_in;
   logic [tfp_pkg::BYTE_W-1:0]     ident_ff, ident_in;
   logic [tfp_pkg::SEQ_W-1:0]      seq_ff, seq_in;
   logic [tfp_pkg::BYTE_W-1:0]     index_ff, index_in;
   logic [tfp_pkg::BYTE_W:0]       raw_sum;
   logic [tfp_pkg::BYTE_W-1:0]     sum_plus;
   logic [tfp_pkg::SEQ_W:0]        seq_expect;
   logic                           restart;
   logic                           pos_zero;

   // End-around carry: the carry out of the byte add is folded back in.
   assign raw_sum = {1'b0, sum_ff} + {1'b0, beat.rx_byte};
   assign sum_plus = raw_sum[tfp_pkg::BYTE_W-1:0]
                   + {{(tfp_pkg::BYTE_W-1){1'b0}}, raw_sum[tfp_pkg::BYTE_W]};
   assign seq_expect = {1'b0, seq_ff} + {{tfp_pkg::SEQ_W{1'b0}}, 1'b1};
   assign pos_zero = (beat.packet_position == '0);
   assign restart = pos_zero && (beat.rx_byte == '0);

   always_comb begin
      phase_in = phase_ff;
      sum_in = sum_ff;
      length_in = length_ff;
      ident_in = ident_ff;
      seq_in = seq_ff;
      index_in = index_ff;
      result.event_res = tfp_pkg::EV_IGNORED;
      result.payload_byte = '0;
      result.payload_index = '0;
      if (restart) begin
         sum_in = '0;
         length_in = '0;
         ident_in = '0;
         seq_in = '0;
         index_in = '0;
         phase_in = PH_START;
         result.event_res = tfp_pkg::EV_START;
      end else begin
         case (phase_ff)
            PH_IDLE, PH_ERROR: begin
               phase_in = PH_ERROR;
               result.event_res = tfp_pkg::EV_NO_START;
            end
            PH_START: begin
               length_in = beat.rx_byte;
               sum_in = sum_plus;
               phase_in = PH_LEN;
               result.event_res = tfp_pkg::EV_LENGTH;
            end
            PH_LEN: begin
               ident_in = beat.rx_byte;
               sum_in = sum_plus;
               phase_in = PH_ID;
               result.event_res = tfp_pkg::EV_ID;
            end
            PH_ID: begin
               result.payload_byte = beat.rx_byte;
               result.payload_index = index_ff;
               index_in = index_ff + 8'd1;
               sum_in = sum_plus;
               phase_in = PH_PAYLOAD;
               result.event_res = tfp_pkg::EV_PAYLOAD;
            end
            PH_PAYLOAD, PH_SEQ: begin
               if (phase_ff == PH_PAYLOAD && pos_zero) begin
                  sum_in = sum_plus;
                  if ({1'b0, beat.rx_byte[tfp_pkg::SEQ_W-1:0]} != seq_expect) begin
                     phase_in = PH_ERROR;
                     result.event_res = tfp_pkg::EV_SEQ_ERR;
                  end else begin
                     seq_in = beat.rx_byte[tfp_pkg::SEQ_W-1:0];
                     phase_in = PH_SEQ;
                     result.event_res = tfp_pkg::EV_SEQ_OK;
                  end
               end else if (index_ff < length_ff) begin
                  result.payload_byte = beat.rx_byte;
                  result.payload_index = index_ff;
                  index_in = index_ff + 8'd1;
                  sum_in = sum_plus;
                  phase_in = PH_PAYLOAD;
                  result.event_res = tfp_pkg::EV_PAYLOAD;
               end else if (sum_ff == beat.rx_byte) begin
                  phase_in = PH_DONE;
                  result.event_res = tfp_pkg::EV_DONE;
               end else begin
                  phase_in = PH_ERROR;
                  result.event_res = tfp_pkg::EV_CSUM_ERR;
               end
            end
            default: begin
               result.event_res = tfp_pkg::EV_IGNORED;
            end
         endcase
      end
      result.msg_len = length_in;
      result.msg_id = ident_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         sum_ff <= '0;
         length_ff <= '0;
         ident_ff <= '0;
         seq_ff <= '0;
         index_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         sum_ff <= sum_in;
         length_ff <= length_in;
         ident_ff <= ident_in;
         seq_ff <= seq_in;
         index_ff <= index_in;
      end
   end

endmodule

FILE: hw/rtl/telemetry_frame_parser.sv
// Byte-serial parser for short telemetry messages spread over small link
// packets. Each request beat carries one received byte and its position in
// the link packet, and each beat produces exactly one response beat with an
// event code, the payload byte and its index when the event is a payload
// byte, and the current message length and identifier. The block takes one
// beat per cycle while the response side is not stalled. An accepted request
// beat is held in the input register; the parser updates the message state
// from it, and the result register loads the result as the response beat.
// Backpressure on the response side stalls the pipeline without losing beats.
module telemetry_frame_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] rx_byte, [10:8] packet_position, [15:11] zero
   input  logic [tfp_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] payload_byte, [15:8] payload_index, [23:16] msg_len, [31:24] msg_id
   output logic [tfp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [3:0] event_res, [7:4] zero
   output logic [tfp_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   logic                  beat_valid;
   logic                  advance;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   tfp_pkg::in_beat_type  beat;
   tfp_pkg::result_type   result;
   tfp_pkg::result_type   result_ff;

   assign advance = beat_valid && (!out_valid_ff || rsp_tready);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   tfp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   tfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .beat    (beat),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {result_ff.msg_id, result_ff.msg_len,
                       result_ff.payload_index, result_ff.payload_byte};
   assign rsp_tuser = {{(tfp_pkg::RSP_USER_W-4){1'b0}}, result_ff.event_res};

endmodule

FILE: hw/rtl/tfp_checker.sv
module tfp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [tfp_pkg::REQ_DATA_W-1:0]     req_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [tfp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [tfp_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   logic payload_beat;
   logic start_beat;

   assign payload_beat = (rsp_tuser[3:0] == tfp_pkg::EV_PAYLOAD);
   assign start_beat = (rsp_tuser[3:0] == tfp_pkg::EV_START);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled response beat changed.");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Response beat present right after reset.");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !payload_beat |-> rsp_tdata[15:0] == '0)
      else $error("Payload fields nonzero on a non-payload beat.");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && start_beat |-> rsp_tdata[31:16] == '0)
      else $error("Start beat carries a stale length or identifier.");

   a_start_restart_byte: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[10:0] == '0 && !rsp_tvalid
         && !$past(req_tvalid && req_tready) |=>
         ##1 rsp_tvalid && start_beat)
      else $error("Restart byte did not produce a start beat.");

endmodule

bind telemetry_frame_parser tfp_checker u_tfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
